// ===== design/csf_pkg.sv =====
// types, constants and the milliamp conversion for the current-sense filter block
// used by current_sense_filter_calibrate_trace; depends on nothing else

package csf_pkg;

  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_TICK   = 2'd1,
    OP_CALIB  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CAL_PASS   = 2'd0,
    CAL_FAIL   = 2'd1,
    CAL_REJECT = 2'd2
  } cal_status_e;

  typedef enum logic [1:0] {
    HEALTH_UNKNOWN  = 2'd0,
    HEALTH_CHECKING = 2'd1,
    HEALTH_OK       = 2'd2,
    HEALTH_ERROR    = 2'd3
  } health_e;

  // configuration register indexes
  localparam logic [2:0] CFG_ZERO_POINT  = 3'd0;
  localparam logic [2:0] CFG_MEAN_LOW    = 3'd1;
  localparam logic [2:0] CFG_MEAN_HIGH   = 3'd2;
  localparam logic [2:0] CFG_MAX_RANGE   = 3'd3;
  localparam logic [2:0] CFG_MAX_SPREAD  = 3'd4;

  localparam logic [9:0] ZERO_POINT_RST  = 10'd512;
  localparam logic [9:0] MEAN_LOW_RST    = 10'd400;
  localparam logic [9:0] MEAN_HIGH_RST   = 10'd624;
  localparam logic [7:0] MAX_RANGE_RST   = 8'd20;
  localparam logic [7:0] MAX_SPREAD_RST  = 8'd6;
  localparam logic [9:0] SAMPLE_MAX      = 10'd1023;

  // 74.02 mA per count: integer part times d, fraction as (2d+50)/100
  localparam logic [16:0] MA_SCALE_INT   = 17'd74;
  localparam logic [11:0] MA_ROUND       = 12'd50;
  localparam logic [13:0] MA_RECIP       = 14'd10486;   // ceil(2^20/100)
  localparam int          MA_RECIP_SHIFT = 20;

  // trace units of 125 mA, rounded
  localparam logic [16:0] TICK_ROUND     = 17'd62;
  localparam logic [16:0] TICK_RECIP     = 17'd67109;   // ceil(2^23/125)
  localparam int          TICK_SHIFT     = 23;

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cur_ma;
    logic [7:0]  tv;
    logic        rd_hit;
    logic [6:0]  count;
    logic [1:0]  status;
    logic [9:0]  cmean;
    logic [7:0]  crange;
    logic [7:0]  cspread;
    logic [1:0]  health;
    logic [13:0] slow_avg;
    logic [9:0]  zp;
    logic        primed;
  } stage_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cur_ma;
    logic [15:0] disp_ma;
    logic [7:0]  tv;
    logic [6:0]  count;
    logic [1:0]  status;
    logic [9:0]  cmean;
    logic [7:0]  crange;
    logic [7:0]  cspread;
    logic [1:0]  health;
  } result_t;

  function automatic logic [15:0] counts_to_ma(logic [9:0] adc, logic [9:0] zp);
    logic [9:0]  d;
    logic [11:0] n;
    logic [25:0] qp;
    logic [4:0]  q;
    logic [16:0] v;
    d  = (adc > zp) ? adc - zp : zp - adc;
    n  = {1'b0, d, 1'b0} + MA_ROUND;
    qp = 26'(n) * 26'(MA_RECIP);
    q  = qp[MA_RECIP_SHIFT+4:MA_RECIP_SHIFT];
    v  = 17'(d) * MA_SCALE_INT + 17'(q);
    return (v > 17'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== design/current_sense_filter_calibrate_trace.sv =====
// current-sense filter top level: dual moving average, trace ring, calibration
// depends on csf_pkg

// One request is taken per clock cycle while in_stall_o is low, of any kind.
// On its way out a result passes a first register stage, which holds the
// updated state and the registered trace memory read, and then a second one,
// a four-entry output queue. in_stall_o rises only when the
// queue together with the stage holds four results, so a stalled consumer
// costs no throughput until the queue fills. Calibration samples with the motor
// off that do not finish a 128-sample run produce no result. The trace ring is a
// TRACE_DEPTH x 8 memory with one write and one registered read port; it needs
// no clearing after reset because the fill count hides entries never written.
// Configuration writes should only be issued while no request is in flight.

module current_sense_filter_calibrate_trace #(
  parameter int TRACE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [9:0]  cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [9:0]  adc_sample_i,
  input  logic        motor_off_i,
  input  logic [5:0]  trace_position_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] current_ma_o,
  output logic [15:0] display_current_ma_o,
  output logic [7:0]  trace_value_o,
  output logic [6:0]  trace_count_o,
  output logic [1:0]  calib_status_o,
  output logic [9:0]  calib_mean_o,
  output logic [7:0]  calib_range_o,
  output logic [7:0]  calib_spread_o,
  output logic [1:0]  health_o
);

  localparam int HW   = $clog2(TRACE_DEPTH);
  localparam int FW   = $clog2(TRACE_DEPTH + 1);
  localparam int SUMW = ((HW > 6) ? HW : 6) + 1;
  localparam int OQ_DEPTH = csf_pkg::OQ_DEPTH;

  // configuration
  logic [9:0] mean_low_q, mean_low_d, mean_high_q, mean_high_d;
  logic [7:0] max_range_q, max_range_d, max_spread_q, max_spread_d;

  // filter state
  logic [12:0] fast_avg_q, fast_avg_d;
  logic [13:0] slow_avg_q, slow_avg_d;
  logic        primed_q, primed_d;
  logic [9:0]  zero_point_q, zero_point_d;
  logic [15:0] latest_q, latest_d;

  // trace state
  logic [HW-1:0] trace_head_q, trace_head_d;
  logic [FW-1:0] trace_fill_q, trace_fill_d;
  logic [7:0]    trace_mem [TRACE_DEPTH];
  logic [7:0]    rd_data_q;
  logic          tick_we, rd_en;
  logic [HW-1:0] rd_idx;
  logic [HW-1:0] rd_start;
  logic [SUMW-1:0] rd_sum;
  logic          rd_hit;
  logic [7:0]    tick_value;
  logic [16:0]   tick_num;
  logic [33:0]   tick_prod;
  logic [9:0]    tick_q10;

  // calibration state
  logic [6:0]  cal_idx_q, cal_idx_d;
  logic [14:0] cal_bsum_q, cal_bsum_d;
  logic [16:0] cal_total_q, cal_total_d;
  logic [9:0]  cal_min_q, cal_min_d, cal_max_q, cal_max_d;
  logic [9:0]  blk_min_q, blk_min_d, blk_max_q, blk_max_d;
  csf_pkg::health_e health_q, health_d;
  logic        cal_clear;

  // filter datapath
  logic [12:0] fa_base, fa_new, fa_round;
  logic [13:0] sa_base, sa_new;
  logic signed [13:0] f_diff, f_sum;
  logic signed [14:0] s_diff, s_sum;

  // calibration datapath
  logic [9:0]  cmin_new, cmax_new, blk_avg, bmin_new, bmax_new, cal_mean;
  logic [14:0] bsum_new, bsum_rnd;
  logic [16:0] total_new, total_rnd;
  logic [9:0]  range_full, spread_full;
  logic [7:0]  cal_range, cal_spread;
  logic        blk_end, first_blk, cal_done, cal_pass;

  // pipeline
  logic            in_acc;
  csf_pkg::op_e    op;
  logic            s1_valid_q, s1_valid_d;
  csf_pkg::stage_t s1_q, s1_d;
  csf_pkg::result_t res_d;
  logic [13:0]     slow_rnd;

  csf_pkg::result_t outq_mem [OQ_DEPTH];
  logic [csf_pkg::OQ_AW-1:0] oq_wr_q, oq_rd_q;
  logic [csf_pkg::OQ_CW-1:0] oq_cnt_q;
  logic oq_push, oq_pop;
  csf_pkg::result_t oq_head;

  assign op     = csf_pkg::op_e'(op_i);
  assign in_acc = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------- filters
  always_comb begin
    fa_base  = primed_q ? fast_avg_q : {adc_sample_i, 3'b000};
    sa_base  = primed_q ? slow_avg_q : {adc_sample_i, 4'b0000};
    f_diff   = $signed({1'b0, adc_sample_i, 3'b000}) - $signed({1'b0, fa_base});
    s_diff   = $signed({1'b0, adc_sample_i, 4'b0000}) - $signed({1'b0, sa_base});
    f_sum    = $signed({1'b0, fa_base}) + (f_diff >>> 3);
    s_sum    = $signed({1'b0, sa_base}) + (s_diff >>> 4);
    fa_new   = f_sum[12:0];
    sa_new   = s_sum[13:0];
    fa_round = fa_new + 13'd4;
  end

  // ---------------------------------------------------------------- trace
  always_comb begin
    tick_num   = 17'(latest_q) + csf_pkg::TICK_ROUND;
    tick_prod  = 34'(tick_num) * 34'(csf_pkg::TICK_RECIP);
    tick_q10   = tick_prod[csf_pkg::TICK_SHIFT+9:csf_pkg::TICK_SHIFT];
    tick_value = (tick_q10 > 10'd255) ? 8'd255 : tick_q10[7:0];

    // oldest entry sits at the head once the ring has wrapped
    rd_start = (trace_fill_q == FW'(TRACE_DEPTH)) ? trace_head_q : '0;
    rd_sum   = SUMW'(rd_start) + SUMW'(trace_position_i);
    rd_idx   = (rd_sum >= SUMW'(TRACE_DEPTH)) ? HW'(rd_sum - SUMW'(TRACE_DEPTH))
                                              : HW'(rd_sum);
    rd_hit   = SUMW'(trace_position_i) < SUMW'(trace_fill_q);
    tick_we  = in_acc && (op == csf_pkg::OP_TICK);
    rd_en    = in_acc && (op == csf_pkg::OP_READ);
  end

  always_ff @(posedge clk_i) begin
    if (tick_we) begin
      trace_mem[trace_head_q] <= tick_value;
    end
    if (rd_en) begin
      rd_data_q <= trace_mem[rd_idx];
    end
  end

  // ---------------------------------------------------------------- calibration
  always_comb begin
    cmin_new   = (adc_sample_i < cal_min_q) ? adc_sample_i : cal_min_q;
    cmax_new   = (adc_sample_i > cal_max_q) ? adc_sample_i : cal_max_q;
    bsum_new   = cal_bsum_q + 15'(adc_sample_i);
    total_new  = cal_total_q + 17'(adc_sample_i);
    bsum_rnd   = bsum_new + 15'd16;
    blk_avg    = bsum_rnd[14:5];
    total_rnd  = total_new + 17'd64;
    cal_mean   = total_rnd[16:7];
    blk_end    = &cal_idx_q[4:0];
    first_blk  = (cal_idx_q[6:5] == 2'd0);
    cal_done   = &cal_idx_q;
    bmin_new   = (first_blk || blk_avg < blk_min_q) ? blk_avg : blk_min_q;
    bmax_new   = (first_blk || blk_avg > blk_max_q) ? blk_avg : blk_max_q;
    range_full = cmax_new - cmin_new;
    spread_full = bmax_new - bmin_new;
    cal_range  = (range_full > 10'd255) ? 8'd255 : range_full[7:0];
    cal_spread = (spread_full > 10'd255) ? 8'd255 : spread_full[7:0];
    cal_pass   = (cal_mean >= mean_low_q) && (cal_mean <= mean_high_q) &&
                 (cal_range <= max_range_q) && (cal_spread <= max_spread_q);
  end

  // ---------------------------------------------------------------- state update
  always_comb begin
    mean_low_d   = mean_low_q;
    mean_high_d  = mean_high_q;
    max_range_d  = max_range_q;
    max_spread_d = max_spread_q;
    fast_avg_d   = fast_avg_q;
    slow_avg_d   = slow_avg_q;
    primed_d     = primed_q;
    zero_point_d = zero_point_q;
    latest_d     = latest_q;
    trace_head_d = trace_head_q;
    trace_fill_d = trace_fill_q;
    cal_idx_d    = cal_idx_q;
    cal_bsum_d   = cal_bsum_q;
    cal_total_d  = cal_total_q;
    cal_min_d    = cal_min_q;
    cal_max_d    = cal_max_q;
    blk_min_d    = blk_min_q;
    blk_max_d    = blk_max_q;
    health_d     = health_q;
    cal_clear    = 1'b0;
    s1_valid_d   = in_acc;

    s1_d         = '0;
    s1_d.kind    = op_i;

    if (in_acc) begin
      case (op)
        csf_pkg::OP_FILTER: begin
          fast_avg_d = fa_new;
          slow_avg_d = sa_new;
          primed_d   = 1'b1;
          latest_d   = csf_pkg::counts_to_ma(fa_round[12:3], zero_point_q);
        end
        csf_pkg::OP_TICK: begin
          s1_d.tv      = tick_value;
          trace_head_d = (trace_head_q == HW'(TRACE_DEPTH - 1)) ? '0
                                                                : trace_head_q + 1'b1;
          if (trace_fill_q != FW'(TRACE_DEPTH)) begin
            trace_fill_d = trace_fill_q + 1'b1;
          end
        end
        csf_pkg::OP_READ: begin
          s1_d.rd_hit = rd_hit;
        end
        csf_pkg::OP_CALIB: begin
          if (!motor_off_i) begin
            cal_clear   = 1'b1;
            s1_d.status = csf_pkg::CAL_REJECT;
          end else begin
            if (cal_idx_q == '0) begin
              health_d = csf_pkg::HEALTH_CHECKING;
            end
            cal_min_d   = cmin_new;
            cal_max_d   = cmax_new;
            cal_bsum_d  = blk_end ? '0 : bsum_new;
            cal_total_d = total_new;
            cal_idx_d   = cal_idx_q + 1'b1;
            if (blk_end) begin
              blk_min_d = bmin_new;
              blk_max_d = bmax_new;
            end
            if (cal_done) begin
              s1_d.cmean   = cal_mean;
              s1_d.crange  = cal_range;
              s1_d.cspread = cal_spread;
              cal_clear    = 1'b1;
              if (cal_pass) begin
                zero_point_d = cal_mean;
                fast_avg_d   = {cal_mean, 3'b000};
                slow_avg_d   = {cal_mean, 4'b0000};
                primed_d     = 1'b1;
                latest_d     = '0;
                health_d     = csf_pkg::HEALTH_OK;
                s1_d.status  = csf_pkg::CAL_PASS;
              end else begin
                health_d     = csf_pkg::HEALTH_ERROR;
                s1_d.status  = csf_pkg::CAL_FAIL;
              end
            end else begin
              // mid-run sample, nothing to report
              s1_valid_d = 1'b0;
            end
          end
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end

    if (cal_clear) begin
      cal_idx_d   = '0;
      cal_bsum_d  = '0;
      cal_total_d = '0;
      cal_min_d   = csf_pkg::SAMPLE_MAX;
      cal_max_d   = '0;
      blk_min_d   = '0;
      blk_max_d   = '0;
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        csf_pkg::CFG_ZERO_POINT: zero_point_d = cfg_wdata_i;
        csf_pkg::CFG_MEAN_LOW:   mean_low_d   = cfg_wdata_i;
        csf_pkg::CFG_MEAN_HIGH:  mean_high_d  = cfg_wdata_i;
        csf_pkg::CFG_MAX_RANGE:  max_range_d  = cfg_wdata_i[7:0];
        csf_pkg::CFG_MAX_SPREAD: max_spread_d = cfg_wdata_i[7:0];
        default: ;
      endcase
    end

    s1_d.cur_ma   = latest_d;
    s1_d.count    = 7'(trace_fill_d);
    s1_d.health   = health_d;
    s1_d.slow_avg = slow_avg_d;
    s1_d.zp       = zero_point_d;
    s1_d.primed   = primed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_low_q   <= csf_pkg::MEAN_LOW_RST;
      mean_high_q  <= csf_pkg::MEAN_HIGH_RST;
      max_range_q  <= csf_pkg::MAX_RANGE_RST;
      max_spread_q <= csf_pkg::MAX_SPREAD_RST;
      fast_avg_q   <= '0;
      slow_avg_q   <= '0;
      primed_q     <= 1'b0;
      zero_point_q <= csf_pkg::ZERO_POINT_RST;
      latest_q     <= '0;
      trace_head_q <= '0;
      trace_fill_q <= '0;
      cal_idx_q    <= '0;
      cal_bsum_q   <= '0;
      cal_total_q  <= '0;
      cal_min_q    <= csf_pkg::SAMPLE_MAX;
      cal_max_q    <= '0;
      blk_min_q    <= '0;
      blk_max_q    <= '0;
      health_q     <= csf_pkg::HEALTH_UNKNOWN;
      s1_valid_q   <= 1'b0;
    end else begin
      mean_low_q   <= mean_low_d;
      mean_high_q  <= mean_high_d;
      max_range_q  <= max_range_d;
      max_spread_q <= max_spread_d;
      fast_avg_q   <= fast_avg_d;
      slow_avg_q   <= slow_avg_d;
      primed_q     <= primed_d;
      zero_point_q <= zero_point_d;
      latest_q     <= latest_d;
      trace_head_q <= trace_head_d;
      trace_fill_q <= trace_fill_d;
      cal_idx_q    <= cal_idx_d;
      cal_bsum_q   <= cal_bsum_d;
      cal_total_q  <= cal_total_d;
      cal_min_q    <= cal_min_d;
      cal_max_q    <= cal_max_d;
      blk_min_q    <= blk_min_d;
      blk_max_q    <= blk_max_d;
      health_q     <= health_d;
      s1_valid_q   <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------- second stage
  always_comb begin
    slow_rnd      = s1_q.slow_avg + 14'd8;
    res_d.kind    = s1_q.kind;
    res_d.cur_ma  = s1_q.cur_ma;
    res_d.disp_ma = s1_q.primed ? csf_pkg::counts_to_ma(slow_rnd[13:4], s1_q.zp) : '0;
    res_d.tv      = s1_q.rd_hit ? rd_data_q : s1_q.tv;
    res_d.count   = s1_q.count;
    res_d.status  = s1_q.status;
    res_d.cmean   = s1_q.cmean;
    res_d.crange  = s1_q.crange;
    res_d.cspread = s1_q.cspread;
    res_d.health  = s1_q.health;
  end

  // ---------------------------------------------------------------- output queue
  assign oq_push     = s1_valid_q;
  assign out_valid_o = (oq_cnt_q != '0);
  assign oq_pop      = out_valid_o & ~out_stall_i;
  // room must remain for the stage entry and one more request
  assign in_stall_o  = (csf_pkg::OQ_CW'(oq_cnt_q) + csf_pkg::OQ_CW'(s1_valid_q)) >=
                       csf_pkg::OQ_CW'(OQ_DEPTH);

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      outq_mem[oq_wr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= (oq_wr_q == csf_pkg::OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= (oq_rd_q == csf_pkg::OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_q <= oq_cnt_q - 1'b1;
      end
    end
  end

  assign oq_head              = outq_mem[oq_rd_q];
  assign result_kind_o        = oq_head.kind;
  assign current_ma_o         = oq_head.cur_ma;
  assign display_current_ma_o = oq_head.disp_ma;
  assign trace_value_o        = oq_head.tv;
  assign trace_count_o        = oq_head.count;
  assign calib_status_o       = oq_head.status;
  assign calib_mean_o         = oq_head.cmean;
  assign calib_range_o        = oq_head.crange;
  assign calib_spread_o       = oq_head.cspread;
  assign health_o             = oq_head.health;

  // ---------------------------------------------------------------- checks
  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (csf_pkg::OQ_CW'(oq_cnt_q) + csf_pkg::OQ_CW'(s1_valid_q)) <=
      csf_pkg::OQ_CW'(OQ_DEPTH))
    else $error("output queue overrun");

  a_head_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trace_fill_q != FW'(TRACE_DEPTH)) |-> (FW'(trace_head_q) == trace_fill_q))
    else $error("trace head and fill disagree before wrap");

  a_cal_checking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cal_idx_q != '0) |-> (health_q == csf_pkg::HEALTH_CHECKING))
    else $error("calibration run without checking health");

  a_blk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cal_idx_q[6:5] != 2'd0) |-> (blk_min_q <= blk_max_q))
    else $error("block average min above max");

  a_rezero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.kind == csf_pkg::OP_CALIB && s1_q.status == csf_pkg::CAL_PASS)
      |-> (zero_point_q == s1_q.cmean))
    else $error("passed calibration did not re-zero");

endmodule
